// File: hdl/prdl_pkg.sv
// Shared types, constants and a helper function for the Pollard rho discrete log block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package prdl_pkg;

    localparam int WORD_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int CNT_BITS  = $clog2(PROD_BITS + 1);
    localparam int COEF_BITS = WORD_BITS + 2;

    typedef struct packed {
        logic [WORD_BITS-1:0] modulus;
        logic [WORD_BITS-1:0] group_order;
        logic [WORD_BITS-1:0] generator;
        logic [WORD_BITS-1:0] target;
    } in_item_t;

    typedef struct packed {
        logic [15:0] logarithm;
        logic        found;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK_START,
        ST_WALK_WAIT,
        ST_COMPARE,
        ST_EUC_LOOP,
        ST_EUC_WAIT,
        ST_INV,
        ST_RES_WAIT,
        ST_PUBLISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MISS,
        OP_WALK_START,
        OP_WALK_FINISH,
        OP_ITER_INC,
        OP_EUC_INIT,
        OP_EUC_START,
        OP_EUC_UPDATE,
        OP_INV_START,
        OP_RESULT,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic fast;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic guard_zero;
        logic iter_done;
        logic collide;
        logic ra_zero;
        logic out_free;
    } status_t;

    // Residue modulo three by summing base-four digits, whose weights are each one modulo three.
    function automatic logic [1:0] mod3(input logic [WORD_BITS-1:0] v);
        logic [6:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        logic [2:0] s4;
        s1 = '0;
        for (int k = 0; k < WORD_BITS / 2; k++) begin
            s1 = s1 + 7'(v[2*k +: 2]);
        end
        s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]) + 4'(s1[6]);
        s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
        s4 = 3'(s3[1:0]) + 3'(s3[2]);
        if (s4 >= 3'd3) begin
            s4 = s4 - 3'd3;
        end
        return s4[1:0];
    endfunction

endpackage

// File: hdl/prdl_ctrl.sv
// Controller state machine that sequences the walk, the collision check and Euclid.
// Depends on prdl_pkg; drives commands to prdl_dp and reads its status.
`timescale 1ns / 1ps

module prdl_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  prdl_pkg::status_t status,
    output prdl_pkg::cmd_t    cmd
);

    prdl_pkg::state_t state_reg;
    prdl_pkg::state_t state_next;
    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prdl_pkg::ST_IDLE;
            phase_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            prdl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = prdl_pkg::ST_CHECK;
                end
            end
            prdl_pkg::ST_CHECK:
            begin
                phase_next = 2'd0;
                if (status.guard_zero || status.iter_done)
                begin
                    state_next = prdl_pkg::ST_PUBLISH;
                end
                else
                begin
                    state_next = prdl_pkg::ST_WALK_START;
                end
            end
            prdl_pkg::ST_WALK_START:
            begin
                state_next = prdl_pkg::ST_WALK_WAIT;
            end
            prdl_pkg::ST_WALK_WAIT:
            begin
                if (!status.div_busy)
                begin
                    if (phase_reg == 2'd2)
                    begin
                        state_next = prdl_pkg::ST_COMPARE;
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                        state_next = prdl_pkg::ST_WALK_START;
                    end
                end
            end
            prdl_pkg::ST_COMPARE:
            begin
                if (status.collide)
                begin
                    state_next = prdl_pkg::ST_EUC_LOOP;
                end
                else
                begin
                    state_next = prdl_pkg::ST_CHECK;
                end
            end
            prdl_pkg::ST_EUC_LOOP:
            begin
                if (status.ra_zero)
                begin
                    state_next = prdl_pkg::ST_INV;
                end
                else
                begin
                    state_next = prdl_pkg::ST_EUC_WAIT;
                end
            end
            prdl_pkg::ST_EUC_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = prdl_pkg::ST_EUC_LOOP;
                end
            end
            prdl_pkg::ST_INV:
            begin
                state_next = prdl_pkg::ST_RES_WAIT;
            end
            prdl_pkg::ST_RES_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = prdl_pkg::ST_PUBLISH;
                end
            end
            prdl_pkg::ST_PUBLISH:
            begin
                if (status.out_free)
                begin
                    state_next = prdl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = prdl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op   = prdl_pkg::OP_NONE;
        cmd.fast = (phase_reg != 2'd0);
        in_ready = 1'b0;
        unique case (state_reg)
            prdl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = prdl_pkg::OP_LOAD;
                end
            end
            prdl_pkg::ST_CHECK:
            begin
                if (status.guard_zero || status.iter_done)
                begin
                    cmd.op = prdl_pkg::OP_MISS;
                end
            end
            prdl_pkg::ST_WALK_START:
            begin
                cmd.op = prdl_pkg::OP_WALK_START;
            end
            prdl_pkg::ST_WALK_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.op = prdl_pkg::OP_WALK_FINISH;
                end
            end
            prdl_pkg::ST_COMPARE:
            begin
                if (status.collide)
                begin
                    cmd.op = prdl_pkg::OP_EUC_INIT;
                end
                else
                begin
                    cmd.op = prdl_pkg::OP_ITER_INC;
                end
            end
            prdl_pkg::ST_EUC_LOOP:
            begin
                if (!status.ra_zero)
                begin
                    cmd.op = prdl_pkg::OP_EUC_START;
                end
            end
            prdl_pkg::ST_EUC_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.op = prdl_pkg::OP_EUC_UPDATE;
                end
            end
            prdl_pkg::ST_INV:
            begin
                cmd.op = prdl_pkg::OP_INV_START;
            end
            prdl_pkg::ST_RES_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.op = prdl_pkg::OP_RESULT;
                end
            end
            prdl_pkg::ST_PUBLISH:
            begin
                if (status.out_free)
                begin
                    cmd.op = prdl_pkg::OP_PUBLISH;
                end
            end
            default:
            begin
                cmd.op = prdl_pkg::OP_NONE;
            end
        endcase
    end

endmodule

// File: hdl/prdl_dp.sv
// Datapath with walk registers, a shared bit-serial divider, Euclid registers and output stage.
// Depends on prdl_pkg; controlled by prdl_ctrl through command and status structs.
`timescale 1ns / 1ps

module prdl_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  prdl_pkg::in_item_t  in_data,
    input  prdl_pkg::cmd_t      cmd,
    output prdl_pkg::status_t   status,
    input  logic                out_ready,
    output logic                out_valid,
    output prdl_pkg::out_item_t out_data
);

    localparam int W = prdl_pkg::WORD_BITS;
    localparam int P = prdl_pkg::PROD_BITS;
    localparam int C = prdl_pkg::COEF_BITS;

    logic [W-1:0] p_reg, n_reg, g_reg, t_reg;
    logic [W-1:0] xs_reg, as_reg, bs_reg, xf_reg, af_reg, bf_reg;
    logic [W-1:0] iter_reg;
    logic [W-1:0] ra_reg, rb_reg, da_reg;
    logic signed [C-1:0] ta_reg, tb_reg;
    logic [15:0]  log_reg;
    logic         found_reg;
    logic         out_valid_reg;
    prdl_pkg::out_item_t out_data_reg;

    logic [P-1:0] dvd_reg;
    logic [W-1:0] dvs_reg;
    logic [W-1:0] rem_reg;
    logic [prdl_pkg::CNT_BITS-1:0] cnt_reg;
    logic         busy_reg;

    logic [W-1:0] x_cur, a_cur, b_cur, a_new, b_new, mul_op;
    logic [1:0]   res3;
    logic [W:0]   a_inc, b_inc, a_dbl, b_dbl;
    logic [W:0]   da_sum, db_sum;
    logic [W-1:0] da_val, db_val;
    logic [W:0]   rem_sh;
    logic         rem_ge;
    logic signed [C+W:0] q_prod;
    logic signed [C-1:0] inv_s;
    logic [W-1:0] inv_val;
    logic         div_start;
    logic [P-1:0] div_dvd;
    logic [W-1:0] div_dvs;

    assign x_cur = cmd.fast ? xf_reg : xs_reg;
    assign a_cur = cmd.fast ? af_reg : as_reg;
    assign b_cur = cmd.fast ? bf_reg : bs_reg;
    assign res3  = prdl_pkg::mod3(x_cur);

    assign a_inc = {1'b0, a_cur} + {{W{1'b0}}, 1'b1};
    assign b_inc = {1'b0, b_cur} + {{W{1'b0}}, 1'b1};
    assign a_dbl = {a_cur, 1'b0};
    assign b_dbl = {b_cur, 1'b0};

    always_comb
    begin
        a_new  = a_cur;
        b_new  = b_cur;
        mul_op = g_reg;
        case (res3)
            2'd1:
            begin
                b_new  = (b_inc >= {1'b0, n_reg}) ? W'(b_inc - {1'b0, n_reg}) : b_inc[W-1:0];
                mul_op = t_reg;
            end
            2'd0:
            begin
                a_new  = (a_dbl >= {1'b0, n_reg}) ? W'(a_dbl - {1'b0, n_reg}) : a_dbl[W-1:0];
                b_new  = (b_dbl >= {1'b0, n_reg}) ? W'(b_dbl - {1'b0, n_reg}) : b_dbl[W-1:0];
                mul_op = x_cur;
            end
            default:
            begin
                a_new  = (a_inc >= {1'b0, n_reg}) ? W'(a_inc - {1'b0, n_reg}) : a_inc[W-1:0];
                mul_op = g_reg;
            end
        endcase
    end

    assign da_sum = {1'b0, af_reg} + {1'b0, n_reg} - {1'b0, as_reg};
    assign db_sum = {1'b0, bs_reg} + {1'b0, n_reg} - {1'b0, bf_reg};
    assign da_val = (da_sum >= {1'b0, n_reg}) ? W'(da_sum - {1'b0, n_reg}) : da_sum[W-1:0];
    assign db_val = (db_sum >= {1'b0, n_reg}) ? W'(db_sum - {1'b0, n_reg}) : db_sum[W-1:0];

    assign q_prod  = $signed({1'b0, dvd_reg[W-1:0]}) * ta_reg;
    assign inv_s   = (tb_reg < 0) ? (tb_reg + $signed({2'b00, n_reg})) : tb_reg;
    assign inv_val = inv_s[W-1:0];

    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = p_reg;
        case (cmd.op)
            prdl_pkg::OP_WALK_START:
            begin
                div_start = 1'b1;
                div_dvd   = mul_op * x_cur;
                div_dvs   = p_reg;
            end
            prdl_pkg::OP_EUC_START:
            begin
                div_start = 1'b1;
                div_dvd   = P'(rb_reg);
                div_dvs   = ra_reg;
            end
            prdl_pkg::OP_INV_START:
            begin
                div_start = 1'b1;
                div_dvd   = da_reg * inv_val;
                div_dvs   = n_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign rem_sh = {rem_reg, dvd_reg[P-1]};
    assign rem_ge = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (div_start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= prdl_pkg::CNT_BITS'(P);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == prdl_pkg::CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            dvd_reg <= div_dvd;
            dvs_reg <= div_dvs;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_ge ? W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[W-1:0];
            dvd_reg <= {dvd_reg[P-2:0], rem_ge};
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            prdl_pkg::OP_LOAD:
            begin
                p_reg    <= in_data.modulus;
                n_reg    <= in_data.group_order;
                g_reg    <= in_data.generator;
                t_reg    <= in_data.target;
                xs_reg   <= W'(1);
                xf_reg   <= W'(1);
                as_reg   <= '0;
                bs_reg   <= '0;
                af_reg   <= '0;
                bf_reg   <= '0;
                iter_reg <= '0;
            end
            prdl_pkg::OP_MISS:
            begin
                log_reg   <= '0;
                found_reg <= 1'b0;
            end
            prdl_pkg::OP_WALK_START:
            begin
                if (cmd.fast)
                begin
                    af_reg <= a_new;
                    bf_reg <= b_new;
                end
                else
                begin
                    as_reg <= a_new;
                    bs_reg <= b_new;
                end
            end
            prdl_pkg::OP_WALK_FINISH:
            begin
                if (cmd.fast)
                begin
                    xf_reg <= rem_reg;
                end
                else
                begin
                    xs_reg <= rem_reg;
                end
            end
            prdl_pkg::OP_ITER_INC:
            begin
                iter_reg <= iter_reg + 1'b1;
            end
            prdl_pkg::OP_EUC_INIT:
            begin
                ra_reg <= n_reg;
                rb_reg <= db_val;
                ta_reg <= '0;
                tb_reg <= C'(1);
                da_reg <= da_val;
            end
            prdl_pkg::OP_EUC_UPDATE:
            begin
                rb_reg <= ra_reg;
                ra_reg <= rem_reg;
                ta_reg <= C'(tb_reg - q_prod);
                tb_reg <= ta_reg;
            end
            prdl_pkg::OP_RESULT:
            begin
                log_reg   <= 16'(rem_reg);
                found_reg <= 1'b1;
            end
            default:
            begin
                iter_reg <= iter_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == prdl_pkg::OP_PUBLISH)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == prdl_pkg::OP_PUBLISH)
        begin
            out_data_reg.logarithm <= log_reg;
            out_data_reg.found     <= found_reg;
        end
    end

    assign status.div_busy   = busy_reg;
    assign status.guard_zero = (p_reg == '0) || (n_reg == '0);
    assign status.iter_done  = (iter_reg == p_reg);
    assign status.collide    = (xs_reg == xf_reg) && (bs_reg != bf_reg);
    assign status.ra_zero    = (ra_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: hdl/pollard_rho_discrete_log.sv
// A problem is accepted in the idle cycle. Each walk iteration then runs a check state, three
// walk steps (start, the bit-serial divider run, finish) and a compare state. At most modulus
// iterations run. After a collision each Euclid step runs the divider, followed by a last loop
// check and the final product reduction; then the output register is loaded.
// A new problem is taken in the cycle after the result is loaded; rst_n (asynchronous, active
// low) returns the controller to idle and empties the output.
`timescale 1ns / 1ps

module pollard_rho_discrete_log
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  prdl_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output prdl_pkg::out_item_t out_data
);

    prdl_pkg::cmd_t    cmd;
    prdl_pkg::status_t status;

    prdl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    prdl_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // A transaction on the input is followed by a busy block.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // The divider is never restarted while it is still working.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == prdl_pkg::OP_WALK_START || cmd.op == prdl_pkg::OP_EUC_START ||
         cmd.op == prdl_pkg::OP_INV_START) |-> !status.div_busy)
        else $error("divider started while busy");

    // A result without a collision always carries a zero logarithm.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |-> (out_data.logarithm == 16'd0))
        else $error("nonzero logarithm without collision");

endmodule

// File: test/pollard_rho_discrete_log_test.sv
// Self-checking testbench for the Pollard rho discrete log block.
// It drives problems over the input channel, predicts each result and checks the output channel.
// Depends on prdl_pkg and the pollard_rho_discrete_log top level.
`timescale 1ns / 1ps

module pollard_rho_discrete_log_test;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    prdl_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    prdl_pkg::out_item_t out_data;

    prdl_pkg::in_item_t  pending_q[$];
    prdl_pkg::out_item_t logs_q[$];
    int        hold_at;
    int        sent_count;
    int        result_count;
    int        found_count;
    int        mismatches;
    int        in_idle;
    int        out_idle;
    bit        quiet;

    pollard_rho_discrete_log DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic void rho_move(inout longint unsigned x, inout longint unsigned a,
                                     inout longint unsigned b, input longint unsigned g,
                                     input longint unsigned t, input longint unsigned p,
                                     input longint unsigned n);
        longint unsigned r;
        r = x % 3;
        if (r == 1)
        begin
            b = (b + 1) % n;
            a = a % n;
            x = (t * x) % p;
        end
        else if (r == 0)
        begin
            a = (2 * a) % n;
            b = (2 * b) % n;
            x = (x * x) % p;
        end
        else
        begin
            a = (a + 1) % n;
            b = b % n;
            x = (g * x) % p;
        end
    endfunction

    function automatic longint bezout_coef(input longint unsigned m, input longint unsigned v);
        longint unsigned quo[96];
        longint unsigned ra;
        longint unsigned rb;
        longint unsigned t;
        longint cx;
        longint cy;
        longint nx;
        int depth;
        ra = m;
        rb = v;
        depth = 0;
        cx = 0;
        cy = 1;
        while (ra != 0 && depth < 96)
        begin
            quo[depth] = rb / ra;
            depth++;
            t = rb % ra;
            rb = ra;
            ra = t;
        end
        for (int i = depth - 1; i >= 0; i--)
        begin
            nx = cy - longint'(quo[i]) * cx;
            cy = cx;
            cx = nx;
        end
        return cy;
    endfunction

    function automatic prdl_pkg::out_item_t solve_log(input prdl_pkg::in_item_t item);
        prdl_pkg::out_item_t res;
        longint unsigned p, n, g, t;
        longint unsigned xs, as_, bs, xf, af, bf;
        longint unsigned db, da, inv;
        longint y;
        longint yr;
        p = item.modulus;
        n = item.group_order;
        g = item.generator;
        t = item.target;
        res = '0;
        xs = 1;
        xf = 1;
        as_ = 0;
        bs = 0;
        af = 0;
        bf = 0;
        if (n == 0 || p == 0)
        begin
            return res;
        end
        for (longint unsigned i = 0; i < p; i++)
        begin
            rho_move(xs, as_, bs, g, t, p, n);
            rho_move(xf, af, bf, g, t, p, n);
            rho_move(xf, af, bf, g, t, p, n);
            if (xs == xf && bs != bf)
            begin
                db = (bs + n - bf) % n;
                y = bezout_coef(n, db);
                yr = y % longint'(n);
                if (yr < 0)
                begin
                    yr = yr + longint'(n);
                end
                inv = unsigned'(yr);
                da = (af + n - as_) % n;
                res.logarithm = 16'((da * inv) % n);
                res.found = 1'b1;
                return res;
            end
        end
        return res;
    endfunction

    function automatic prdl_pkg::in_item_t make_problem(input int p, input int n, input int g,
                                                        input int t);
        prdl_pkg::in_item_t item;
        item.modulus = 16'(p);
        item.group_order = 16'(n);
        item.generator = 16'(g);
        item.target = 16'(t);
        return item;
    endfunction

    // Input driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            in_idle <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                logs_q.push_back(solve_log(in_data));
                sent_count <= sent_count + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (in_idle > 0)
                begin
                    in_valid <= 1'b0;
                    in_idle <= in_idle - 1;
                end
                else if (pending_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (sent_count + (in_valid ? 1 : 0) == hold_at
                         && (in_valid || logs_q.size() != 0))
                begin
                    in_valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 5) == 0)
                begin
                    in_valid <= 1'b0;
                    in_idle <= $urandom_range(0, 4);
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_q.pop_front();
                end
            end
        end
    end

    // Output monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_idle <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_count <= result_count + 1;
                if (logs_q.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                    begin
                        $display("Unexpected result transaction: logarithm %0d found %0d",
                                 out_data.logarithm, out_data.found);
                    end
                end
                else
                begin
                    prdl_pkg::out_item_t want;
                    want = logs_q.pop_front();
                    if (want.found)
                    begin
                        found_count <= found_count + 1;
                    end
                    if (want.logarithm !== out_data.logarithm || want.found !== out_data.found)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                        begin
                            $display("Mismatch: expected logarithm %0d found %0d, got %0d %0d",
                                     want.logarithm, want.found,
                                     out_data.logarithm, out_data.found);
                        end
                    end
                end
            end
            if (out_idle > 0)
            begin
                out_ready <= 1'b0;
                out_idle <= out_idle - 1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                out_idle <= $urandom_range(0, 4);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #400000000;
        $display("Timeout waiting for the block to finish.");
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int p;
        rst_n = 1'b0;
        sent_count = 0;
        result_count = 0;
        found_count = 0;
        mismatches = 0;
        quiet = 1'b0;
        hold_at = 0;
        pending_q.push_back(make_problem(0, 10, 2, 3));
        pending_q.push_back(make_problem(11, 0, 2, 3));
        pending_q.push_back(make_problem(1, 5, 2, 3));
        pending_q.push_back(make_problem(2, 1, 1, 1));
        pending_q.push_back(make_problem(11, 10, 2, 7));
        pending_q.push_back(make_problem(23, 11, 4, 9));
        pending_q.push_back(make_problem(13, 12, 2, 13));
        pending_q.push_back(make_problem(17, 16, 65535, 65535));
        pending_q.push_back(make_problem(19, 65535, 0, 0));
        pending_q.push_back(make_problem(65535, 65535, 65535, 1));
        pending_q.push_back(make_problem(65521, 65520, 17, 0));
        pending_q.push_back(make_problem(32768, 43690, 21845, 1));
        pending_q.push_back(make_problem(7, 6, 3, 3));
        pending_q.push_back(make_problem(5, 4, 2, 4));
        pending_q.push_back(make_problem(29, 28, 2, 1));
        pending_q.push_back(make_problem(3, 2, 2, 2));
        hold_at = pending_q.size();
        for (int k = 0; k < 100; k++)
        begin
            p = (k % 8 == 0) ? $urandom_range(2, 120) : $urandom_range(2, 48);
            pending_q.push_back(make_problem(p,
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, p),
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, p - 1),
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, p - 1)));
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_q.size() < 15);
        quiet = 1'b1;
        wait (pending_q.size() == 0 && !in_valid);
        wait (logs_q.size() == 0);
        repeat (300) @(posedge clk);
        $display("Ran %0d problems and checked %0d results, %0d with a collision found.",
                 sent_count, result_count, found_count);
        $display("Covered zero and unit moduli, zero group order and full-width fields.");
        if (mismatches == 0 && logs_q.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches.", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/prdl_pkg.sv
hdl/prdl_ctrl.sv
hdl/prdl_dp.sv
hdl/pollard_rho_discrete_log.sv
test/pollard_rho_discrete_log_test.sv
